/* rtl/arc_pkg.sv */
package arc_pkg;

    // Cache geometry.
    localparam int CACHE_ENTRIES = 128;
    localparam int ADDR_W        = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(CACHE_ENTRIES + 1);
    localparam int COUNT_OUT_W   = 8;

    // Field widths.
    localparam int MAC_W     = 48;
    localparam int IP_W      = 32;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 1;

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_OWN_IP  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC = 1'b1;

    // Input command codes.
    localparam logic COMMAND_RX      = 1'b0;
    localparam logic COMMAND_RESOLVE = 1'b1;

    // ARP header values, network order.
    localparam logic [15:0] MIN_LENGTH = 16'd28;
    localparam logic [15:0] HW_ETHERNET = 16'h0001;
    localparam logic [15:0] PROTO_IPV4  = 16'h0800;
    localparam logic [7:0]  HW_LEN_ETH  = 8'd6;
    localparam logic [7:0]  PROTO_LEN_IP = 8'd4;
    localparam logic [15:0] OP_REQUEST  = 16'd1;
    localparam logic [15:0] OP_REPLY    = 16'd2;

    localparam logic [MAC_W-1:0] MAC_BCAST = {MAC_W{1'b1}};

    // Result action codes.
    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_REPLY   = 2'd1;
    localparam logic [1:0] ACT_REQUEST = 2'd2;

    // Opcode of a sent frame.
    localparam logic [1:0] FOP_NONE    = 2'd0;
    localparam logic [1:0] FOP_REQUEST = 2'd1;
    localparam logic [1:0] FOP_REPLY   = 2'd2;

    // Work handed from the front to the back.
    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_REPLY,
        CMD_LEARN,
        CMD_RESOLVE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [MAC_W-1:0] mac;
        logic [IP_W-1:0]  ip;
    } cmd_t;

    typedef struct packed {
        logic [1:0]       action;
        logic [1:0]       frame_opcode;
        logic [MAC_W-1:0] dst_mac;
        logic [IP_W-1:0]  dst_ip;
        logic             lookup_hit;
        logic [MAC_W-1:0] lookup_mac;
    } res_t;

    typedef struct packed {
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } entry_t;

    function automatic res_t res_none();
        res_t r;
        r = '0;
        r.action       = ACT_NONE;
        r.frame_opcode = FOP_NONE;
        return r;
    endfunction

    function automatic res_t res_reply(logic [MAC_W-1:0] mac, logic [IP_W-1:0] ip);
        res_t r;
        r = '0;
        r.action       = ACT_REPLY;
        r.frame_opcode = FOP_REPLY;
        r.dst_mac      = mac;
        r.dst_ip       = ip;
        return r;
    endfunction

    function automatic res_t res_miss(logic [IP_W-1:0] ip);
        res_t r;
        r = '0;
        r.action       = ACT_REQUEST;
        r.frame_opcode = FOP_REQUEST;
        r.dst_mac      = MAC_BCAST;
        r.dst_ip       = ip;
        r.lookup_hit   = 1'b0;
        r.lookup_mac   = MAC_BCAST;
        return r;
    endfunction

    function automatic res_t res_hit(logic [MAC_W-1:0] mac);
        res_t r;
        r = '0;
        r.lookup_hit = 1'b1;
        r.lookup_mac = mac;
        return r;
    endfunction

endpackage

/* rtl/arc_front.sv */
module arc_front import arc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_command,
    input  logic [15:0]          s_frame_length,
    input  logic [15:0]          s_hw_type,
    input  logic [15:0]          s_proto_type,
    input  logic [7:0]           s_hw_len,
    input  logic [7:0]           s_proto_len,
    input  logic [15:0]          s_opcode,
    input  logic [MAC_W-1:0]     s_sender_mac,
    input  logic [IP_W-1:0]      s_sender_ip,
    input  logic [IP_W-1:0]      s_target_ip,
    input  logic [IP_W-1:0]      s_query_ip,
    output logic                 q_valid,
    output cmd_t                 q_cmd,
    input  logic                 q_ready
);

    logic [IP_W-1:0] own_ip_reg;
    logic            hold_valid_reg;
    cmd_t            hold_cmd_reg;
    cmd_t            cmd_next;
    logic            msg_ok;
    logic            accept;

    // A message counts only with a sane header aimed at this station.
    assign msg_ok = (s_frame_length >= MIN_LENGTH) && (s_hw_type == HW_ETHERNET) &&
                    (s_proto_type == PROTO_IPV4) && (s_hw_len == HW_LEN_ETH) &&
                    (s_proto_len == PROTO_LEN_IP) && (s_target_ip == own_ip_reg);

    always_comb begin
        cmd_next.mac  = s_sender_mac;
        cmd_next.ip   = s_sender_ip;
        cmd_next.kind = CMD_NONE;
        if (s_command == COMMAND_RESOLVE) begin
            cmd_next.kind = CMD_RESOLVE;
            cmd_next.ip   = s_query_ip;
        end else if (msg_ok && s_opcode == OP_REQUEST) begin
            cmd_next.kind = CMD_REPLY;
        end else if (msg_ok && s_opcode == OP_REPLY) begin
            cmd_next.kind = CMD_LEARN;
        end
    end

    assign s_ready = !hold_valid_reg || q_ready;
    assign accept  = s_valid && s_ready;
    assign q_valid = hold_valid_reg;
    assign q_cmd   = hold_cmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_ip_reg     <= '0;
            hold_valid_reg <= 1'b0;
        end else begin
            if (cfg_we && cfg_index == REG_OWN_IP) begin
                own_ip_reg <= cfg_wdata[IP_W-1:0];
            end
            if (accept) begin
                hold_valid_reg <= 1'b1;
            end else if (q_ready) begin
                hold_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            hold_cmd_reg <= cmd_next;
        end
    end

endmodule

/* rtl/arc_queue.sv */
module arc_queue import arc_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    input  cmd_t in_cmd,
    output logic in_ready,
    output logic out_valid,
    output cmd_t out_cmd,
    input  logic out_pop
);

    cmd_t              slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] fill_reg;
    logic              push;
    logic              pop;

    assign in_ready  = fill_reg != QCNT_W'(QUEUE_DEPTH);
    assign out_valid = fill_reg != '0;
    assign out_cmd   = slots_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    function automatic logic [QPTR_W-1:0] wrap_inc(logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

/* rtl/arc_back.sv */
module arc_back import arc_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    input  cmd_t                   q_cmd,
    output logic                   q_pop,
    output logic                   out_valid,
    output res_t                   out_res,
    output logic [COUNT_OUT_W-1:0] out_count,
    input  logic                   out_ready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } state_t;

    state_t                 state_reg,     state_next;
    logic [CNT_W-1:0]       count_reg,     count_next;
    logic [CNT_W-1:0]       rd_idx_reg,    rd_idx_next;
    logic                   cmp_valid_reg, cmp_valid_next;
    logic [IP_W-1:0]        query_reg,     query_next;
    res_t                   res_reg,       res_next;
    logic                   out_valid_reg, out_valid_next;
    res_t                   out_res_reg,   out_res_next;
    logic [COUNT_OUT_W-1:0] out_count_reg, out_count_next;

    entry_t cache_mem [CACHE_ENTRIES];
    entry_t rd_entry_reg;

    logic full;
    logic wr_en;
    logic rd_en;
    logic match;

    assign full  = count_reg == CNT_W'(CACHE_ENTRIES);
    assign q_pop = (state_reg == ST_IDLE) && q_valid;
    assign wr_en = q_pop && (q_cmd.kind == CMD_LEARN) && !full;
    assign rd_en = (state_reg == ST_SEARCH) && (rd_idx_reg < count_reg);
    assign match = cmp_valid_reg && (rd_entry_reg.ip == query_reg);

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_valid_next = cmp_valid_reg;
        query_next     = query_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        out_count_next = out_count_reg;

        if (out_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    res_next   = res_none();
                    state_next = ST_DONE;
                    case (q_cmd.kind)
                        CMD_REPLY: begin
                            res_next = res_reply(q_cmd.mac, q_cmd.ip);
                        end
                        CMD_LEARN: begin
                            if (!full) begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_RESOLVE: begin
                            query_next     = q_cmd.ip;
                            rd_idx_next    = '0;
                            cmp_valid_next = 1'b0;
                            state_next     = ST_SEARCH;
                        end
                        default: begin
                            res_next = res_none();
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                // One entry is read per cycle; its compare follows in the next cycle.
                cmp_valid_next = rd_en;
                if (rd_en) begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if (match) begin
                    // A cached broadcast address is treated as unresolved.
                    if (rd_entry_reg.mac == MAC_BCAST) begin
                        res_next = res_miss(query_reg);
                    end else begin
                        res_next = res_hit(rd_entry_reg.mac);
                    end
                    state_next = ST_DONE;
                end else if (!rd_en && !cmp_valid_reg) begin
                    res_next   = res_miss(query_reg);
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || out_ready) begin
                    out_valid_next = 1'b1;
                    out_res_next   = res_reg;
                    out_count_next = COUNT_OUT_W'(count_reg);
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
        rd_idx_reg    <= rd_idx_next;
        query_reg     <= query_next;
        res_reg       <= res_next;
        out_res_reg   <= out_res_next;
        out_count_reg <= out_count_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            cache_mem[count_reg[ADDR_W-1:0]] <= '{ip: q_cmd.ip, mac: q_cmd.mac};
        end
        if (rd_en) begin
            rd_entry_reg <= cache_mem[rd_idx_reg[ADDR_W-1:0]];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign out_count = out_count_reg;

endmodule

/* rtl/arp_responder_with_cache.sv */
// ARP responder with an address cache.
// The input channel (s_valid/s_ready) carries one word per command: either the
// parsed fields of a received ARP message or an IPv4 address to resolve. The
// result channel (m_valid/m_ready) returns exactly one word per command, in
// order: a reply to send, a broadcast request to send, a lookup outcome, or
// nothing sent, always with the cache fill count after the command.
// Own IP and own MAC are to be written through cfg_we/cfg_index/cfg_wdata
// only while idle; the block itself does not enforce this. A received
// message passes from the front's holding stage through the queue to the
// back, whose result goes to the output register. A resolve scans the cache
// memory one entry per cycle, oldest first, and stops at the first match.
// The back works on one command at a time while later words wait upstream.
// Reset clears own IP, the fill count and all handshake state; the cache memory
// itself is not cleared, as entries beyond the fill count are never read.
// When the receiver stalls, the finished word waits in the output register
// while the front keeps taking words into its holding stage and a two-word
// queue; s_ready drops only once both are full.
module arp_responder_with_cache import arc_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_command,
    input  logic [15:0]            s_frame_length,
    input  logic [15:0]            s_hw_type,
    input  logic [15:0]            s_proto_type,
    input  logic [7:0]             s_hw_len,
    input  logic [7:0]             s_proto_len,
    input  logic [15:0]            s_opcode,
    input  logic [MAC_W-1:0]       s_sender_mac,
    input  logic [IP_W-1:0]        s_sender_ip,
    input  logic [IP_W-1:0]        s_target_ip,
    input  logic [IP_W-1:0]        s_query_ip,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [1:0]             m_action,
    output logic [1:0]             m_frame_opcode,
    output logic [MAC_W-1:0]       m_frame_dst_mac,
    output logic [IP_W-1:0]        m_frame_dst_ip,
    output logic                   m_lookup_hit,
    output logic [MAC_W-1:0]       m_lookup_mac,
    output logic [COUNT_OUT_W-1:0] m_entry_count_out
);

    // Front to queue.
    logic fq_valid;
    cmd_t fq_cmd;
    logic fq_ready;

    // Queue to back.
    logic qb_valid;
    cmd_t qb_cmd;
    logic qb_pop;

    res_t out_res;

    // The front checks the header and the target address against own IP and
    // reduces each word to a reply, a cache append, a resolve or nothing.
    // Own MAC is accepted on the port but is only the sender of sent frames,
    // which no result field shows, so it is not stored.
    arc_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_frame_length (s_frame_length),
        .s_hw_type      (s_hw_type),
        .s_proto_type   (s_proto_type),
        .s_hw_len       (s_hw_len),
        .s_proto_len    (s_proto_len),
        .s_opcode       (s_opcode),
        .s_sender_mac   (s_sender_mac),
        .s_sender_ip    (s_sender_ip),
        .s_target_ip    (s_target_ip),
        .s_query_ip     (s_query_ip),
        .q_valid        (fq_valid),
        .q_cmd          (fq_cmd),
        .q_ready        (fq_ready)
    );

    arc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_cmd    (fq_cmd),
        .in_ready  (fq_ready),
        .out_valid (qb_valid),
        .out_cmd   (qb_cmd),
        .out_pop   (qb_pop)
    );

    // The back owns the cache memory and the fill count, runs the search and
    // holds the output register.
    arc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (qb_valid),
        .q_cmd     (qb_cmd),
        .q_pop     (qb_pop),
        .out_valid (m_valid),
        .out_res   (out_res),
        .out_count (m_entry_count_out),
        .out_ready (m_ready)
    );

    assign m_action        = out_res.action;
    assign m_frame_opcode  = out_res.frame_opcode;
    assign m_frame_dst_mac = out_res.dst_mac;
    assign m_frame_dst_ip  = out_res.dst_ip;
    assign m_lookup_hit    = out_res.lookup_hit;
    assign m_lookup_mac    = out_res.lookup_mac;

endmodule
